// ----- hdl/edqt_pkg.sv -----
// ----------------------------------------------------------------------------
// edqt_pkg: shared types and constants for the edge deque degree tracker
// Operation and status codes, vertex id width and the degree update flags.
// ----------------------------------------------------------------------------
package edqt_pkg;

  localparam int unsigned VERTEX_W   = 8;
  localparam int unsigned VERTEX_IDS = 2 ** VERTEX_W;
  localparam int unsigned EDGE_W     = 2 * VERTEX_W;

  // result field widths
  localparam int unsigned EDGE_COUNT_W = 7;
  localparam int unsigned OVER_TWO_W   = 9;
  localparam int unsigned QUERY_DEG_W  = 8;

  // degree thresholds: entering / leaving the "three or more" group
  localparam int unsigned DEG_ENTER_HIGH = 2;
  localparam int unsigned DEG_LEAVE_HIGH = 3;

  typedef enum logic [1:0] {
    OP_PUSH      = 2'd0,
    OP_POP_BACK  = 2'd1,
    OP_POP_FRONT = 2'd2,
    OP_QUERY     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // degree update unit -> sequencer
  typedef struct packed {
    logic wr_en;    // write the new degree back
    logic tot_inc;  // vertex enters the high-degree group
    logic tot_dec;  // vertex leaves the high-degree group
  } alu_flags_t;

endpackage

// ----- hdl/edqt_deg_alu.sv -----
// ----------------------------------------------------------------------------
// edqt_deg_alu: shared degree increment / decrement unit
// One edge end per use; flags tell the sequencer how the high-degree total moves.
// ----------------------------------------------------------------------------
module edqt_deg_alu #(
  parameter int unsigned DEG_W = 8
) (
  input  logic [DEG_W-1:0]       deg_i,
  input  logic                   remove_i,
  output logic [DEG_W-1:0]       new_deg_o,
  output edqt_pkg::alu_flags_t   flags_o
);

  logic is_enter;
  logic is_leave;
  logic is_zero;

  assign is_enter = (deg_i == DEG_W'(edqt_pkg::DEG_ENTER_HIGH));
  assign is_leave = (deg_i == DEG_W'(edqt_pkg::DEG_LEAVE_HIGH));
  assign is_zero  = (deg_i == '0);

  always_comb begin
    if (remove_i) begin
      new_deg_o       = deg_i - DEG_W'(1);
      flags_o.wr_en   = !is_zero;   // never drop below zero
      flags_o.tot_inc = 1'b0;
      flags_o.tot_dec = is_leave;
    end else begin
      new_deg_o       = deg_i + DEG_W'(1);
      flags_o.wr_en   = 1'b1;
      flags_o.tot_inc = is_enter;
      flags_o.tot_dec = 1'b0;
    end
  end

endmodule

// ----- hdl/edqt_degree_table.sv -----
// ----------------------------------------------------------------------------
// edqt_degree_table: per-vertex degree memory with valid bits
// One write and one registered read per cycle; unwritten entries read zero.
// ----------------------------------------------------------------------------
module edqt_degree_table #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned DATA_W = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [DATA_W-1:0] data_q;
  logic              hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = hit_q ? data_q : '0;

endmodule

// ----- hdl/edqt_edge_store.sv -----
// ----------------------------------------------------------------------------
// edqt_edge_store: circular edge storage for the deque
// One write port, one registered read port; contents undefined until written.
// ----------------------------------------------------------------------------
module edqt_edge_store #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr_i,
  input  logic [edqt_pkg::EDGE_W-1:0]   wr_data_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr_i,
  output logic [edqt_pkg::EDGE_W-1:0]   rd_data_o
);

  logic [edqt_pkg::EDGE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ----- hdl/edge_deque_degree_tracker_core.sv -----
// ----------------------------------------------------------------------------
// edge_deque_degree_tracker_core: edge deque with vertex degree tracking
// Push/pop edges at either end, keep per-vertex degrees and a count of
// vertices with degree three or more, report the state on every request.
// ----------------------------------------------------------------------------
// One request is handled at a time; s_axis_tready is high only while the
// sequencer is idle. For every edge end, a push reads the degree table in
// S_DEG_RD and writes back through the shared increment/decrement unit in
// S_DEG_WR; a successful pop first takes the popped edge from the edge store
// in S_EDGE and then updates both ends the same way. A query or a refused
// push/pop skips the update. Every request ends in S_FRONT, reading the
// front edge and the queried degree, and in S_DONE, loading the result
// register. The result register lets the next request be accepted while a
// result still waits on m_axis_tready; a new result stalls only if the old
// one has not been taken. Degrees reset to zero through valid bits, so no
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module edge_deque_degree_tracker_core #(
  parameter int unsigned EDGE_DEPTH   = 64,
  parameter int unsigned VERTEX_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // vertex_a[7:0], vertex_b[15:8], query_vertex[23:16]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // edge_count[6:0], queue_empty[7], front_a[15:8],
                                      // front_b[23:16], popped_a[31:24], popped_b[39:32],
                                      // over_two_count[48:40], query_degree[56:49],
                                      // zero[63:57]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  // Only ids below 256 exist, so the table never needs more rows than that.
  localparam int unsigned DEG_DEPTH = (VERTEX_COUNT < edqt_pkg::VERTEX_IDS) ?
                                      VERTEX_COUNT : edqt_pkg::VERTEX_IDS;
  localparam int unsigned VIDX_W    = $clog2(DEG_DEPTH);
  localparam int unsigned PTR_W     = $clog2(EDGE_DEPTH);
  localparam int unsigned OCC_W     = $clog2(EDGE_DEPTH + 1);
  localparam int unsigned DEG_W     = $clog2(2 * EDGE_DEPTH + 1);
  localparam int unsigned TOT_W     = $clog2(DEG_DEPTH + 1);
  localparam int unsigned VW        = edqt_pkg::VERTEX_W;
  localparam int unsigned OUT_W     = 7 + 1 + 4 * VW + edqt_pkg::OVER_TWO_W
                                      + edqt_pkg::QUERY_DEG_W;
  localparam int unsigned QE_BIT    = edqt_pkg::EDGE_COUNT_W;
  localparam int unsigned POP_LSB   = QE_BIT + 1 + 2 * VW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,     // popped edge arrives from the store
    S_DEG_RD,   // read degree of current edge end
    S_DEG_WR,   // update and write back
    S_FRONT,    // read front edge and queried degree
    S_DONE      // load result register
  } state_e;

  state_e             state_q;
  edqt_pkg::op_e      in_op;
  edqt_pkg::status_e  status_q;
  logic [PTR_W-1:0]   head_q, tail_q;
  logic [PTR_W-1:0]   head_next, tail_next, tail_prev;
  logic [OCC_W-1:0]   occ_q;
  logic [TOT_W-1:0]   tot_q;
  logic               end_sel_q;   // 0: first end, 1: second end
  logic               remove_q;
  logic               m_tvalid_q;
  logic [1:0]         m_tuser_q;
  logic [63:0]        m_tdata_q;

  logic [VW-1:0]      vb_q, qv_q, end_v_q, pop_a_q, pop_b_q;

  logic               s_fire, m_fire, out_load;
  logic               is_full, is_empty, pop_ok;

  logic [VIDX_W-1:0]  vidx_lut [edqt_pkg::VERTEX_IDS];

  // edge store port
  logic                        es_wr_en, es_rd_en;
  logic [PTR_W-1:0]            es_rd_addr;
  logic [edqt_pkg::EDGE_W-1:0] es_rd_data;

  // degree table port
  logic                        dt_rd_en, dt_wr_en;
  logic [VIDX_W-1:0]           dt_rd_addr;
  logic [DEG_W-1:0]            dt_rd_data, new_deg;
  edqt_pkg::alu_flags_t        alu_flags;

  logic [VW-1:0]               front_a, front_b;
  logic [OUT_W-1:0]            out_word;

  // vertex id -> table row, ids wrap at VERTEX_COUNT
  for (genvar g = 0; g < edqt_pkg::VERTEX_IDS; g++) begin : g_vidx
    assign vidx_lut[g] = VIDX_W'(g % VERTEX_COUNT);
  end

  assign in_op    = edqt_pkg::op_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign m_fire   = m_tvalid_q && m_axis_tready;
  assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_axis_tready);

  assign is_full  = (occ_q == OCC_W'(EDGE_DEPTH));
  assign is_empty = (occ_q == '0);
  assign pop_ok   = ((in_op == edqt_pkg::OP_POP_BACK) ||
                     (in_op == edqt_pkg::OP_POP_FRONT)) && !is_empty;

  assign head_next = (head_q == PTR_W'(EDGE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
  assign tail_next = (tail_q == PTR_W'(EDGE_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
  assign tail_prev = (tail_q == '0) ? PTR_W'(EDGE_DEPTH - 1) : tail_q - PTR_W'(1);

  // edge store: push writes at tail, pop reads its slot, final read at head
  assign es_wr_en   = s_fire && (in_op == edqt_pkg::OP_PUSH) && !is_full;
  assign es_rd_en   = (s_fire && pop_ok) || (state_q == S_FRONT);
  assign es_rd_addr = (state_q == S_FRONT) ? head_q :
                      (in_op == edqt_pkg::OP_POP_BACK) ? tail_prev : head_q;

  edqt_edge_store #(
    .DEPTH (EDGE_DEPTH)
  ) u_edge_store (
    .clk_i     (clk_i),
    .wr_en_i   (es_wr_en),
    .wr_addr_i (tail_q),
    .wr_data_i ({s_axis_tdata[2*VW-1:VW], s_axis_tdata[VW-1:0]}),
    .rd_en_i   (es_rd_en),
    .rd_addr_i (es_rd_addr),
    .rd_data_o (es_rd_data)
  );

  // degree table: edge ends during update, queried vertex at the end
  assign dt_rd_en   = (state_q == S_DEG_RD) || (state_q == S_FRONT);
  assign dt_rd_addr = (state_q == S_FRONT) ? vidx_lut[qv_q] : vidx_lut[end_v_q];
  assign dt_wr_en   = (state_q == S_DEG_WR) && alu_flags.wr_en;

  edqt_degree_table #(
    .DEPTH  (DEG_DEPTH),
    .DATA_W (DEG_W)
  ) u_degree_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (dt_rd_en),
    .rd_addr_i (dt_rd_addr),
    .rd_data_o (dt_rd_data),
    .wr_en_i   (dt_wr_en),
    .wr_addr_i (vidx_lut[end_v_q]),
    .wr_data_i (new_deg)
  );

  edqt_deg_alu #(
    .DEG_W (DEG_W)
  ) u_deg_alu (
    .deg_i     (dt_rd_data),
    .remove_i  (remove_q),
    .new_deg_o (new_deg),
    .flags_o   (alu_flags)
  );

  // sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      status_q   <= edqt_pkg::ST_OK;
      head_q     <= '0;
      tail_q     <= '0;
      occ_q      <= '0;
      tot_q      <= '0;
      end_sel_q  <= 1'b0;
      remove_q   <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      // a result taken while the next one loads keeps valid high
      if (m_fire && !out_load) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_fire) begin
            end_sel_q <= 1'b0;
            case (in_op)
              edqt_pkg::OP_PUSH: begin
                if (is_full) begin
                  status_q <= edqt_pkg::ST_FULL;
                  state_q  <= S_FRONT;
                end else begin
                  status_q <= edqt_pkg::ST_OK;
                  tail_q   <= tail_next;
                  occ_q    <= occ_q + OCC_W'(1);
                  remove_q <= 1'b0;
                  state_q  <= S_DEG_RD;
                end
              end
              edqt_pkg::OP_POP_BACK, edqt_pkg::OP_POP_FRONT: begin
                if (is_empty) begin
                  status_q <= edqt_pkg::ST_EMPTY;
                  state_q  <= S_FRONT;
                end else begin
                  if (in_op == edqt_pkg::OP_POP_BACK) begin
                    tail_q <= tail_prev;
                  end else begin
                    head_q <= head_next;
                  end
                  status_q <= edqt_pkg::ST_OK;
                  occ_q    <= occ_q - OCC_W'(1);
                  remove_q <= 1'b1;
                  state_q  <= S_EDGE;
                end
              end
              default: begin  // query only
                status_q <= edqt_pkg::ST_OK;
                state_q  <= S_FRONT;
              end
            endcase
          end
        end
        S_EDGE: begin
          state_q <= S_DEG_RD;
        end
        S_DEG_RD: begin
          state_q <= S_DEG_WR;
        end
        S_DEG_WR: begin
          if (alu_flags.tot_inc) begin
            tot_q <= tot_q + TOT_W'(1);
          end else if (alu_flags.tot_dec) begin
            tot_q <= tot_q - TOT_W'(1);
          end
          if (!end_sel_q) begin
            end_sel_q <= 1'b1;
            state_q   <= S_DEG_RD;
          end else begin
            state_q   <= S_FRONT;
          end
        end
        S_FRONT: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            m_tvalid_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // request payload and edge ends
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      vb_q    <= s_axis_tdata[2*VW-1:VW];
      qv_q    <= s_axis_tdata[3*VW-1:2*VW];
      end_v_q <= s_axis_tdata[VW-1:0];
      pop_a_q <= '0;
      pop_b_q <= '0;
    end else if (state_q == S_EDGE) begin
      pop_a_q <= es_rd_data[VW-1:0];
      pop_b_q <= es_rd_data[2*VW-1:VW];
      end_v_q <= es_rd_data[VW-1:0];
      vb_q    <= es_rd_data[2*VW-1:VW];
    end else if ((state_q == S_DEG_WR) && !end_sel_q) begin
      end_v_q <= vb_q;
    end
  end

  assign front_a = is_empty ? '0 : es_rd_data[VW-1:0];
  assign front_b = is_empty ? '0 : es_rd_data[2*VW-1:VW];

  assign out_word = {edqt_pkg::QUERY_DEG_W'(dt_rd_data),
                     edqt_pkg::OVER_TWO_W'(tot_q),
                     pop_b_q, pop_a_q, front_b, front_a,
                     is_empty,
                     edqt_pkg::EDGE_COUNT_W'(occ_q)};

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_tdata_q <= 64'(out_word);
      m_tuser_q <= status_q;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  // checks
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(EDGE_DEPTH))
    else $error("queue occupancy above depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (state_q != S_IDLE))
    else $error("sequencer idle right after a request");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == edqt_pkg::ST_EMPTY)) |->
      (m_axis_tdata[QE_BIT] && (m_axis_tdata[POP_LSB+2*VW-1:POP_LSB] == '0)))
    else $error("refused pop reports a non-empty queue or a popped edge");

  a_tot_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DEG_WR) && alu_flags.tot_dec) |-> (tot_q != '0))
    else $error("high-degree total underflow");

endmodule
